/* rtl/rbm_pkg.sv */
// Shared types and constants of the six-page 8 KB ROM bank mapper.
// Used by rbm_bank_regs, rbm_decode and the top level; depends on nothing.
package rbm_pkg;

	localparam int PAGE_COUNT = 6;
	localparam int OFFSET_BITS = 13;
	localparam int ROM_ADDR_BITS = 21;
	localparam int ROM_BANK_BITS = ROM_ADDR_BITS - OFFSET_BITS;

	localparam logic [15:0] REG_ADDR = 16'h8000;
	localparam logic [15:0] RAM_BASE = 16'hC000;
	localparam logic [15:0] MIRROR_SPLIT = 16'hE000;
	localparam logic [15:0] PAGE_SIZE = 16'h2000;
	localparam logic [7:0] FIXED_BANK = 8'h3C;
	localparam logic [7:0] SCRAMBLE = 8'h22;
	localparam logic [7:0] SCRAMBLE_TRIGGER = 8'hFF;
	localparam logic [7:0] BANK_MASK_RESET = 8'd63;

	// Reset banks of pages 0 to 5, before masking to the bank width.
	localparam logic [7:0] PAGE_RESET [PAGE_COUNT] = '{8'h3C, 8'h3C, 8'h01, 8'h00, 8'h03, 8'h02};
	// XOR applied to the register value for each page; pages 0 and 1 use it only when bit 7 is set.
	localparam logic [7:0] PAGE_XOR [PAGE_COUNT] = '{8'h03, 8'h02, 8'h01, 8'h00, 8'h03, 8'h02};

	typedef enum logic [2:0] {
		KIND_ROM_READ = 3'd0,
		KIND_RAM_READ = 3'd1,
		KIND_REG_WRITE = 3'd2,
		KIND_ROM_IGNORED = 3'd3,
		KIND_RAM_WRITE = 3'd4
	} kind_t;

	typedef enum logic {
		CMD_READ = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [7:0] write_data;
		logic [15:0] address;
		cmd_t cmd;
	} req_t;

	typedef struct packed {
		logic [15:0] mirror_address;
		logic [15:0] ram_address;
		logic [ROM_ADDR_BITS-1:0] rom_address;
		kind_t kind;
	} rsp_t;

endpackage

/* rtl/rom_bank_mapper_six_page_8k_top.sv */
// Top level of the six-page 8 KB ROM bank mapper.
// Depends on rbm_pkg, rbm_bank_regs and rbm_decode.
//
// Usage:
//   Slave stream: one CPU bus access per word. tuser carries the access kind
//   (0 read, 1 write); tdata carries the address and the written byte.
//   Master stream: one result word per access. tuser carries the result kind
//   (ROM read, RAM read, bank register write, ignored ROM write, RAM write);
//   tdata carries the ROM byte address, the RAM address and the mirror address.
//   Config channel: cfg_data loads the bank mask; always ready. Write it only
//   while no access is in flight.
// Timing:
//   A word is held in an input register, translated by short logic against the
//   page bank registers and captured in the result register that drives
//   m_axis_tvalid; one word per cycle sustained while m_axis_tready is high.
//   A bank register write takes effect at the edge it leaves the input stage,
//   so the very next word already sees the new page banks.
// Reset:
//   arst_n clears both stages, sets the bank mask to 63, the bank register to
//   zero and the page banks to 3C, 3C, 01, 00, 03, 02 (masked to BANK_BITS).
// Stall:
//   When the receiver holds m_axis_tready low, hold the result, then hold the
//   input stage; s_axis_tready drops only when both are full.
module rom_bank_mapper_six_page_8k_top import rbm_pkg::*; #(
	parameter int BANK_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
	input logic [0:0] s_axis_tuser,    // [0] cmd
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [55:0] m_axis_tdata,  // [20:0] rom_address, [36:21] ram_address,
	                                   // [52:37] mirror_address, [55:53] zero
	output logic [2:0] m_axis_tuser,   // [2:0] kind
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data         // [7:0] bank_mask
);

	logic [7:0] bank_mask_q;
	logic s1_valid_q;
	req_t req_s1;
	logic out_valid_q;
	rsp_t rsp_q;

	logic out_free;
	logic advance;
	logic accept;
	logic load;
	rsp_t rsp;
	logic [PAGE_COUNT-1:0][BANK_BITS-1:0] page_bank;

	// Configuration: take a word whenever offered.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_mask_q <= BANK_MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bank_mask_q <= cfg_data;
		end
	end

	// Handshake: the input stage moves on when the result slot is free.
	assign out_free = !out_valid_q || m_axis_tready;
	assign advance = s1_valid_q && out_free;
	assign s_axis_tready = !s1_valid_q || out_free;
	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the incoming word.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.cmd <= cmd_t'(s_axis_tuser[0]);
			req_s1.address <= s_axis_tdata[15:0];
			req_s1.write_data <= s_axis_tdata[23:16];
		end
	end

	rbm_decode #(
		.BANK_BITS(BANK_BITS)
	) u_decode (
		.req(req_s1),
		.page_bank(page_bank),
		.rsp(rsp),
		.load(load)
	);

	// Update the banks only once the register write leaves the input stage.
	rbm_bank_regs #(
		.BANK_BITS(BANK_BITS)
	) u_bank_regs (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && load),
		.load_data(req_s1.write_data),
		.bank_mask(bank_mask_q),
		.page_bank(page_bank)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = rsp_q.kind;
	assign m_axis_tdata = {3'b000, rsp_q.mirror_address, rsp_q.ram_address, rsp_q.rom_address};

endmodule

/* rtl/rbm_bank_regs.sv */
// Bank register and the six page bank registers of the mapper.
// Depends on rbm_pkg.
module rbm_bank_regs import rbm_pkg::*; #(
	parameter int BANK_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic [7:0] load_data,
	input logic [7:0] bank_mask,
	output logic [PAGE_COUNT-1:0][BANK_BITS-1:0] page_bank
);

	logic [7:0] bank_register_q;
	logic [PAGE_COUNT-1:0][BANK_BITS-1:0] page_bank_q;
	logic [7:0] value;
	logic [BANK_BITS-1:0] mask;
	logic [PAGE_COUNT-1:0][BANK_BITS-1:0] page_next;

	assign mask = bank_mask[BANK_BITS-1:0];

	always_comb begin
		value = load_data;
		if (bank_register_q == SCRAMBLE_TRIGGER) begin
			value = load_data ^ SCRAMBLE;
		end
		for (int p = 0; p < PAGE_COUNT; p++) begin
			page_next[p] = BANK_BITS'(value ^ PAGE_XOR[p]) & mask;
		end
		// Low two pages fall back to the fixed bank unless bit 7 is set.
		if (!value[7]) begin
			page_next[0] = FIXED_BANK[BANK_BITS-1:0] & mask;
			page_next[1] = FIXED_BANK[BANK_BITS-1:0] & mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_register_q <= '0;
			for (int p = 0; p < PAGE_COUNT; p++) begin
				page_bank_q[p] <= PAGE_RESET[p][BANK_BITS-1:0];
			end
		end else if (load) begin
			bank_register_q <= value;
			page_bank_q <= page_next;
		end
	end

	assign page_bank = page_bank_q;

endmodule

/* rtl/rbm_decode.sv */
// Access decode and address translation for one bus word.
// Depends on rbm_pkg.
module rbm_decode import rbm_pkg::*; #(
	parameter int BANK_BITS = 8
) (
	input req_t req,
	input logic [PAGE_COUNT-1:0][BANK_BITS-1:0] page_bank,
	output rsp_t rsp,
	output logic load
);

	logic is_rom_area;
	logic [BANK_BITS-1:0] bank;

	assign is_rom_area = req.address < RAM_BASE;

	always_comb begin
		case (req.address[15:OFFSET_BITS])
			3'd0: bank = page_bank[0];
			3'd1: bank = page_bank[1];
			3'd2: bank = page_bank[2];
			3'd3: bank = page_bank[3];
			3'd4: bank = page_bank[4];
			3'd5: bank = page_bank[5];
			default: bank = '0;
		endcase
	end

	always_comb begin
		rsp = '0;
		load = 1'b0;
		if (is_rom_area) begin
			if (req.cmd == CMD_READ) begin
				rsp.kind = KIND_ROM_READ;
				rsp.rom_address = {ROM_BANK_BITS'(bank), req.address[OFFSET_BITS-1:0]};
			end else if (req.address == REG_ADDR) begin
				rsp.kind = KIND_REG_WRITE;
				load = 1'b1;
			end else begin
				rsp.kind = KIND_ROM_IGNORED;
			end
		end else begin
			rsp.ram_address = req.address;
			if (req.cmd == CMD_READ) begin
				rsp.kind = KIND_RAM_READ;
			end else begin
				rsp.kind = KIND_RAM_WRITE;
				if (req.address < MIRROR_SPLIT) begin
					rsp.mirror_address = req.address + PAGE_SIZE;
				end else begin
					rsp.mirror_address = req.address - PAGE_SIZE;
				end
			end
		end
	end

endmodule
